### hdl/x86_group3_unary_muldiv_alu_defines.svh
// Assertion macros for the group-3 ALU.
`ifndef X86_GROUP3_UNARY_MULDIV_ALU_DEFINES_SVH
`define X86_GROUP3_UNARY_MULDIV_ALU_DEFINES_SVH
`ifndef SYNTHESIS
// Check that prop holds at every rising clock edge outside reset.
`define G3_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("group3 alu check failed");
// Check that prop never holds outside reset.
`define G3_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("group3 alu forbidden condition seen");
`else
`define G3_ASSERT(lbl, clk, rst_n, prop)
`define G3_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

### hdl/x86g3_pkg.sv
// Types, codes and the divide step function of the group-3 ALU.
`timescale 1ns / 1ps
package x86g3_pkg;

  localparam int unsigned DivSteps = 16;

  typedef enum logic [2:0] {
    CMD_TEST = 3'd0,
    CMD_RSV  = 3'd1,
    CMD_NOT  = 3'd2,
    CMD_NEG  = 3'd3,
    CMD_MUL  = 3'd4,
    CMD_IMUL = 3'd5,
    CMD_DIV  = 3'd6,
    CMD_IDIV = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIV_ERR = 2'd1,
    ST_INV_OP  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_OPND = 2'd1,
    TGT_ACC  = 2'd2
  } target_e;

  typedef enum logic [1:0] {
    FU_NONE = 2'd0,
    FU_CFOF = 2'd1,
    FU_ALL  = 2'd2
  } fupd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic               wide;
    logic               derr;
    status_e            st;
    target_e            tgt;
    fupd_e              fu;
    logic [15:0]        lo;
    logic               cf;
    logic               of;
    logic               zf;
    logic               sf;
    logic               pf;
    logic               af;
    logic signed [16:0] ma;
    logic signed [16:0] mb;
    logic [31:0]        prod;
    logic [15:0]        rem;
    logic [15:0]        dlo;
    logic [15:0]        quo;
    logic [15:0]        dvs;
    logic               sd;
    logic               sv;
  } g3_stage_t;

  // One restoring divide step: shift in the next dividend bit, subtract if it fits.
  function automatic g3_stage_t div_step(g3_stage_t s);
    g3_stage_t  r;
    logic [16:0] t;
    logic        ge;
    r  = s;
    t  = {s.rem, s.dlo[15]};
    ge = (t >= {1'b0, s.dvs});
    r.rem = ge ? 16'(t - {1'b0, s.dvs}) : t[15:0];
    r.dlo = {s.dlo[14:0], 1'b0};
    r.quo = {s.quo[14:0], ge};
    return r;
  endfunction

endpackage

### hdl/x86_group3_unary_muldiv_alu.sv
// Top level of the 8086 group-3 ALU: TEST, NOT, NEG, MUL, IMUL, DIV, IDIV.
`timescale 1ns / 1ps
`include "x86_group3_unary_muldiv_alu_defines.svh"
// Usage:
//   Input channel: in_valid_i with the operation fields; an item is taken at a
//   rising edge with in_valid_i high and in_stall_o low.
//   Output channel: out_valid_o with the result fields; the item is delivered
//   at an edge with out_valid_o high and out_stall_i low.
//   Path from acceptance to out_valid_o: input register, one
//   multiply and divide-check stage, 16 restoring divide stages of one
//   quotient bit each, output register. Every operation takes the same path.
//   Throughput: one item per cycle while no result is held; the 16-stage
//   divide pipeline sets the latency, and no unit is shared between items.
//   Stall: while a result waits on out_stall_i the whole pipeline holds, and
//   in_stall_o rises so no item is taken; nothing is dropped or repeated.
//   Reset: rst_ni clears all valid bits at once; payload registers keep
//   whatever they hold and are ignored until a valid bit reaches them.
//   Divide errors and the reserved code return status with all other fields 0.
module x86_group3_unary_muldiv_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic        operand_width_i,
  input  logic [15:0] rm_value_i,
  input  logic [15:0] imm_value_i,
  input  logic [15:0] acc_low_i,
  input  logic [15:0] acc_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [1:0]  write_target_o,
  output logic [15:0] low_value_o,
  output logic [15:0] high_value_o,
  output logic [1:0]  flag_update_o,
  output logic        carry_flag_o,
  output logic        overflow_flag_o,
  output logic        zero_flag_o,
  output logic        sign_flag_o,
  output logic        parity_flag_o,
  output logic        aux_carry_flag_o
);
  import x86g3_pkg::*;

  localparam int unsigned LastStg = DivSteps + 1;

  logic      adv;
  g3_stage_t in_d;
  g3_stage_t stg_q [LastStg+1];
  g3_stage_t stg_d [LastStg+1];
  logic      stg_valid_q [LastStg+1];

  logic        out_valid_q;
  status_e     out_st_q, out_st_d;
  target_e     out_tgt_q, out_tgt_d;
  fupd_e       out_fu_q, out_fu_d;
  logic [15:0] out_lo_q, out_lo_d, out_hi_q, out_hi_d;
  logic [5:0]  out_fl_q, out_fl_d;  // cf, of, zf, sf, pf, af

  // Advance everything unless a finished result is held by the receiver.
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // Decode and front-end: finish the simple ops, set up multiply and divide.
  always_comb begin
    logic [15:0] mask, rm, imm, r, rmx, sbit;
    logic [31:0] dvd, dmag;
    logic        sx;
    in_d = '0;
    in_d.cmd  = cmd_e'(cmd_i);
    in_d.wide = operand_width_i;
    mask = operand_width_i ? 16'hFFFF : 16'h00FF;
    sbit = operand_width_i ? 16'h8000 : 16'h0080;
    rm   = rm_value_i & mask;
    imm  = imm_value_i & mask;
    sx   = cmd_i[0];
    r    = '0;
    rmx  = '0;
    dvd  = '0;
    dmag = '0;
    unique case (cmd_e'(cmd_i))
      CMD_TEST: begin
        r        = rm & imm;
        in_d.lo  = r;
        in_d.fu  = FU_ALL;
        in_d.zf  = (r == 16'd0);
        in_d.sf  = ((r & sbit) != 16'd0);
        in_d.pf  = ~^r[7:0];
      end
      CMD_RSV: begin
        in_d.st = ST_INV_OP;
      end
      CMD_NOT: begin
        in_d.tgt = TGT_OPND;
        in_d.lo  = ~rm & mask;
      end
      CMD_NEG: begin
        r        = (16'd0 - rm) & mask;
        in_d.tgt = TGT_OPND;
        in_d.lo  = r;
        in_d.fu  = FU_ALL;
        in_d.cf  = (rm != 16'd0);
        in_d.of  = (rm == sbit);
        in_d.af  = (rm[3:0] != 4'd0);
        in_d.zf  = (r == 16'd0);
        in_d.sf  = ((r & sbit) != 16'd0);
        in_d.pf  = ~^r[7:0];
      end
      CMD_MUL, CMD_IMUL: begin
        in_d.tgt = TGT_ACC;
        in_d.fu  = FU_CFOF;
        in_d.ma  = operand_width_i ? {sx & acc_low_i[15], acc_low_i}
                                   : {{9{sx & acc_low_i[7]}}, acc_low_i[7:0]};
        in_d.mb  = operand_width_i ? {sx & rm[15], rm}
                                   : {{9{sx & rm[7]}}, rm[7:0]};
      end
      CMD_DIV, CMD_IDIV: begin
        in_d.tgt = TGT_ACC;
        dvd  = operand_width_i ? {acc_high_i, acc_low_i}
                               : {{16{sx & acc_low_i[15]}}, acc_low_i};
        in_d.sd = sx & dvd[31];
        dmag = in_d.sd ? 32'd0 - dvd : dvd;
        rmx  = operand_width_i ? rm : {{8{sx & rm[7]}}, rm[7:0]};
        in_d.sv  = sx & rmx[15];
        in_d.dvs = in_d.sv ? 16'd0 - rmx : rmx;
        in_d.rem = dmag[31:16];
        in_d.dlo = dmag[15:0];
      end
      default: in_d = '0;
    endcase
  end

  // Stage 1: form the product and check the divide for zero or overflow.
  // Later stages: one quotient bit per stage.
  always_comb begin
    logic signed [33:0] p;
    stg_d[0] = in_d;
    stg_d[1] = stg_q[0];
    p = stg_q[0].ma * stg_q[0].mb;
    stg_d[1].prod = p[31:0];
    stg_d[1].derr = (stg_q[0].dvs == 16'd0) ||
                    (stg_q[0].wide ? (stg_q[0].rem >= stg_q[0].dvs)
                                   : ({8'd0, stg_q[0].dlo[15:8]} >= stg_q[0].dvs));
    for (int k = 2; k <= LastStg; k++) begin
      stg_d[k] = div_step(stg_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LastStg; i++) stg_valid_q[i] <= 1'b0;
    end else if (adv) begin
      stg_valid_q[0] <= in_valid_i;
      for (int i = 1; i <= LastStg; i++) stg_valid_q[i] <= stg_valid_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i <= LastStg; i++) stg_q[i] <= stg_d[i];
    end
  end

  // Back end: fix signs, range-check signed quotients, derive multiply flags.
  always_comb begin
    g3_stage_t   s;
    logic [15:0] mask, lim, qs, rs, hi;
    logic        negq;
    s    = stg_q[LastStg];
    mask = s.wide ? 16'hFFFF : 16'h00FF;
    negq = s.sd ^ s.sv;
    lim  = (s.wide ? 16'h7FFF : 16'h007F) + {15'd0, negq};
    qs   = (negq ? 16'd0 - s.quo : s.quo) & mask;
    rs   = (s.sd ? 16'd0 - s.rem : s.rem) & mask;
    hi   = s.wide ? s.prod[31:16] : {8'd0, s.prod[15:8]};
    out_st_d  = s.st;
    out_tgt_d = s.tgt;
    out_fu_d  = s.fu;
    out_lo_d  = s.lo;
    out_hi_d  = '0;
    out_fl_d  = {s.cf, s.of, s.zf, s.sf, s.pf, s.af};
    unique case (s.cmd)
      CMD_MUL, CMD_IMUL: begin
        out_lo_d = s.wide ? s.prod[15:0] : {8'd0, s.prod[7:0]};
        out_hi_d = hi;
        if (s.cmd == CMD_MUL) begin
          out_fl_d = {{2{hi != 16'd0}}, 4'd0};
        end else if (s.wide) begin
          out_fl_d = {{2{s.prod[31:16] != {16{s.prod[15]}}}}, 4'd0};
        end else begin
          out_fl_d = {{2{s.prod[15:8] != {8{s.prod[7]}}}}, 4'd0};
        end
      end
      CMD_DIV, CMD_IDIV: begin
        out_fl_d = '0;
        if (s.derr || (s.cmd == CMD_IDIV && s.quo > lim)) begin
          out_st_d  = ST_DIV_ERR;
          out_tgt_d = TGT_NONE;
          out_fu_d  = FU_NONE;
          out_lo_d  = '0;
        end else if (s.cmd == CMD_IDIV) begin
          out_lo_d = qs;
          out_hi_d = rs;
        end else begin
          out_lo_d = s.quo & mask;
          out_hi_d = s.rem & mask;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= stg_valid_q[LastStg];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_st_q  <= out_st_d;
      out_tgt_q <= out_tgt_d;
      out_fu_q  <= out_fu_d;
      out_lo_q  <= out_lo_d;
      out_hi_q  <= out_hi_d;
      out_fl_q  <= out_fl_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_st_q;
  assign write_target_o   = out_tgt_q;
  assign flag_update_o    = out_fu_q;
  assign low_value_o      = out_lo_q;
  assign high_value_o     = out_hi_q;
  assign carry_flag_o     = out_fl_q[5];
  assign overflow_flag_o  = out_fl_q[4];
  assign zero_flag_o      = out_fl_q[3];
  assign sign_flag_o      = out_fl_q[2];
  assign parity_flag_o    = out_fl_q[1];
  assign aux_carry_flag_o = out_fl_q[0];

  // Drop of an item between the first two stages would break ordering.
  `G3_ASSERT(a_stage_adv, clk_i, rst_ni, (adv && stg_valid_q[0]) |=> stg_valid_q[1])
  // Input may only stall while a result is held.
  `G3_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o |-> out_valid_o)
  // A divide error writes nothing and clears the result.
  `G3_ASSERT(a_div_err_clean, clk_i, rst_ni,
    (out_valid_o && status_o == ST_DIV_ERR) |->
    (write_target_o == TGT_NONE && flag_update_o == FU_NONE && low_value_o == 16'd0))
  // Multiply flags only travel with an accumulator write.
  `G3_ASSERT_NEVER(a_cfof_tgt, clk_i, rst_ni,
    out_valid_o && flag_update_o == FU_CFOF && write_target_o != TGT_ACC)

endmodule
